FILE: rtl/cda_pkg.sv
// shared types, codes and calendar helpers for the calendar date adder
// no dependencies; imported by every module of the block but cda_cdiv
package cda_pkg;

  typedef enum logic [1:0] {
    OP_ADD_DAYS   = 2'd0,
    OP_ADD_MONTHS = 2'd1,
    OP_ADD_YEARS  = 2'd2,
    OP_LOAD       = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_LOAD  = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam int unsigned AMOUNT_FIELD_W = 16;

  localparam logic [3:0]  MONTH_JAN       = 4'd1;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic [3:0]  MONTH_DEC       = 4'd12;
  localparam logic [4:0]  FIRST_DAY       = 5'd1;
  localparam logic [4:0]  LAST_DAY_DEC    = 5'd31;
  localparam logic [4:0]  FEB_DAYS_LEAP   = 5'd29;
  localparam logic [4:0]  FEB_DAYS_COMMON = 5'd28;

  localparam logic [8:0]  DIVISOR_MONTHS  = 9'd12;
  localparam logic [8:0]  DIVISOR_YEARS   = 9'd400;
  localparam logic [8:0]  YEAR_MOD_LAST   = 9'd399;

  localparam int unsigned RESET_YEAR_VAL  = 2012;
  localparam logic [3:0]  RESET_MONTH     = 4'd7;
  localparam logic [4:0]  RESET_DAY       = 5'd12;
  localparam logic [8:0]  RESET_YEAR_MOD  = 9'(RESET_YEAR_VAL % 400);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] amount;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  status;
  } result_item_t;

  // classified command as it travels through the queue
  typedef struct packed {
    op_t         op;
    logic [15:0] amount;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        load_bad;
  } op_cmd_t;

  // leap test from the year modulo 400
  function automatic logic leap_from_mod(input logic [8:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
           (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                  len = leap ? FEB_DAYS_LEAP : FEB_DAYS_COMMON;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/cda_cdiv.sv
// divider by the constants 12 and 400 using reciprocal multiplication
// no dependencies
module cda_cdiv #(
  parameter int unsigned W = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] value,
  input  logic         by_years,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [8:0]   rem
);

  // x / 12 is (x >> 2) / 3, the low two bits join the remainder
  // x / 400 is (x >> 4) / 25, the low four bits join the remainder
  // ceil(2^17 / 3) is exact below 2^17; month dividends stay below 2^17
  localparam logic [15:0] RECIP_3  = 16'd43691;
  // ceil(2^33 / 25) is exact below 2^30; year dividends reach 2^28 at most
  localparam logic [28:0] RECIP_25 = 29'd343597384;

  logic [31:0] value_ext;
  logic        pend;
  logic        pend_years;
  logic [3:0]  low_bits;
  logic [14:0] by3_op;
  logic [27:0] by25_op;
  logic [30:0] by3_prod;
  logic [56:0] by25_prod;
  logic [14:0] by3_quot;
  logic [1:0]  by3_rem;
  logic [23:0] by25_quot;
  logic [4:0]  by25_rem;

  assign value_ext = 32'(value);

  always_comb begin
    by3_quot  = 15'(by3_prod >> 17);
    by3_rem   = 2'(by3_op - by3_quot * 15'd3);
    by25_quot = 24'(by25_prod >> 33);
    by25_rem  = 5'(by25_op - 28'(by25_quot) * 28'd25);
  end

  // the product is registered first, then quotient and remainder are formed and registered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
      if (start) begin
        pend_years <= by_years;
        low_bits   <= value_ext[3:0];
        by3_op     <= value_ext[16:2];
        by25_op    <= value_ext[31:4];
        by3_prod   <= 31'(value_ext[16:2]) * 31'(RECIP_3);
        by25_prod  <= 57'(value_ext[31:4]) * 57'(RECIP_25);
      end
      if (pend) begin
        if (pend_years) begin
          quot <= W'(by25_quot);
          rem  <= {by25_rem, low_bits};
        end else begin
          quot <= W'(by3_quot);
          rem  <= 9'({by3_rem, low_bits[1:0]});
        end
      end
    end
  end

endmodule

FILE: rtl/cda_exec.sv
// back end: holds the date, executes queued commands and registers the result
// depends on cda_pkg and cda_cdiv
module cda_exec import cda_pkg::*; #(
  parameter int unsigned AMOUNT_WIDTH = 16,
  parameter int unsigned YEAR_WIDTH   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_ready,
  input  op_cmd_t      cmd,
  output logic         cmd_pop,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  localparam int unsigned AMT_W = (AMOUNT_WIDTH < AMOUNT_FIELD_W) ? AMOUNT_WIDTH
                                                                  : AMOUNT_FIELD_W;
  localparam int unsigned DIV_W = (AMT_W + 1 > YEAR_WIDTH) ? AMT_W + 1 : YEAR_WIDTH;
  localparam logic [YEAR_WIDTH-1:0] YMAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_DAYS, S_MONTHS, S_LOAD_CHK, S_REMOD_GO, S_REMOD, S_CLAMP, S_RESULT
  } state_t;

  state_t                state;
  logic [YEAR_WIDTH-1:0] y;
  logic [3:0]            m;
  logic [4:0]            d;
  logic [8:0]            ymod;
  logic [AMT_W-1:0]      rem_days;
  logic [1:0]            status;
  logic [15:0]           ld_year;
  logic [3:0]            ld_month;
  logic [4:0]            ld_day;

  logic                  div_start;
  logic [DIV_W-1:0]      div_value;
  logic                  div_by_years;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic [8:0]            div_rem;

  logic [4:0]            cur_len;
  logic [4:0]            load_len;
  logic [AMT_W:0]        day_sum;
  logic [5:0]            month_rest;
  logic [AMT_W-1:0]      amt;
  logic [DIV_W-1:0]      year_room;

  cda_cdiv #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .value    (div_value),
    .by_years (div_by_years),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    cur_len    = month_len(m, leap_from_mod(ymod));
    load_len   = month_len(ld_month, leap_from_mod(div_rem));
    day_sum    = (AMT_W + 1)'(rem_days) + (AMT_W + 1)'(d);
    month_rest = {1'b0, cur_len} - {1'b0, d} + 6'd1;
    amt        = cmd.amount[AMT_W-1:0];
    year_room  = DIV_W'(YMAX - y);
  end

  assign cmd_pop = (state == S_IDLE) && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      y            <= YEAR_WIDTH'(RESET_YEAR_VAL);
      m            <= RESET_MONTH;
      d            <= RESET_DAY;
      ymod         <= RESET_YEAR_MOD;
      div_start    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_RESULT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_ready) begin
            ld_year  <= cmd.year;
            ld_month <= cmd.month;
            ld_day   <= cmd.day;
            unique case (cmd.op)
              OP_ADD_DAYS: begin
                status   <= STATUS_OK;
                rem_days <= amt;
                state    <= S_DAYS;
              end
              OP_ADD_MONTHS: begin
                status       <= STATUS_OK;
                div_start    <= 1'b1;
                div_by_years <= 1'b0;
                div_value    <= DIV_W'(m - MONTH_JAN) + DIV_W'(amt);
                state        <= S_MONTHS;
              end
              OP_ADD_YEARS: begin
                if (DIV_W'(amt) > year_room) begin
                  y      <= YMAX;
                  m      <= MONTH_DEC;
                  d      <= LAST_DAY_DEC;
                  status <= STATUS_SATURATED;
                end else begin
                  y      <= y + YEAR_WIDTH'(amt);
                  status <= STATUS_OK;
                end
                state <= S_REMOD_GO;
              end
              OP_LOAD: begin
                if (cmd.load_bad) begin
                  status <= STATUS_BAD_LOAD;
                  state  <= S_REMOD_GO;
                end else begin
                  status       <= STATUS_OK;
                  div_start    <= 1'b1;
                  div_by_years <= 1'b1;
                  div_value    <= DIV_W'(cmd.year);
                  state        <= S_LOAD_CHK;
                end
              end
            endcase
          end
        end
        S_DAYS: begin
          if (day_sum <= (AMT_W + 1)'(cur_len)) begin
            d     <= day_sum[4:0];
            state <= S_REMOD_GO;
          end else begin
            rem_days <= rem_days - AMT_W'(month_rest);
            if (m == MONTH_DEC && y == YMAX) begin
              // already at december of the last year, pin the day as well
              d      <= LAST_DAY_DEC;
              status <= STATUS_SATURATED;
              state  <= S_REMOD_GO;
            end else begin
              d <= FIRST_DAY;
              if (m == MONTH_DEC) begin
                y    <= y + YEAR_WIDTH'(1);
                ymod <= (ymod == YEAR_MOD_LAST) ? 9'd0 : ymod + 9'd1;
                m    <= MONTH_JAN;
              end else begin
                m <= m + 4'd1;
              end
            end
          end
        end
        S_MONTHS: begin
          div_start <= 1'b0;
          if (div_done) begin
            if (div_quot > year_room) begin
              y      <= YMAX;
              m      <= MONTH_DEC;
              d      <= LAST_DAY_DEC;
              status <= STATUS_SATURATED;
            end else begin
              y <= y + YEAR_WIDTH'(div_quot);
              m <= div_rem[3:0] + MONTH_JAN;
            end
            state <= S_REMOD_GO;
          end
        end
        S_LOAD_CHK: begin
          div_start <= 1'b0;
          if (div_done) begin
            if (ld_day > load_len) begin
              status <= STATUS_BAD_LOAD;
            end else begin
              y <= YEAR_WIDTH'(ld_year);
              m <= ld_month;
              d <= ld_day;
            end
            state <= S_REMOD_GO;
          end
        end
        S_REMOD_GO: begin
          div_start    <= 1'b1;
          div_by_years <= 1'b1;
          div_value    <= DIV_W'(y);
          state        <= S_REMOD;
        end
        S_REMOD: begin
          div_start <= 1'b0;
          if (div_done) begin
            ymod  <= div_rem;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (d > cur_len) begin
            d <= cur_len;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            result.year   <= 16'(y);
            result.month  <= m;
            result.day    <= d;
            result.status <= status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/cda_fifo.sv
// two-entry command queue between the front and back ends
// depends on cda_pkg for the command type
module cda_fifo import cda_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  op_cmd_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    ready,
  output op_cmd_t pop_data
);

  op_cmd_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign ready    = count != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/cda_front.sv
// front end: takes commands, masks the amount and pre-checks date loads
// depends on cda_pkg
module cda_front import cda_pkg::*; #(
  parameter int unsigned AMOUNT_WIDTH = 16,
  parameter int unsigned YEAR_WIDTH   = 16
) (
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  input  logic      queue_full,
  output logic      push,
  output op_cmd_t   push_data
);

  localparam int unsigned AMT_W = (AMOUNT_WIDTH < AMOUNT_FIELD_W) ? AMOUNT_WIDTH
                                                                  : AMOUNT_FIELD_W;
  localparam int unsigned CMP_W = (YEAR_WIDTH > 16) ? YEAR_WIDTH : 16;
  localparam logic [CMP_W-1:0] YMAX_EXT = CMP_W'({YEAR_WIDTH{1'b1}});

  logic year_bad;
  logic month_bad;
  logic day_bad;

  assign cmd_stall = queue_full;
  assign push      = cmd_valid && !queue_full;

  always_comb begin
    year_bad  = CMP_W'(cmd.load_year) > YMAX_EXT;
    month_bad = (cmd.load_month < MONTH_JAN) || (cmd.load_month > MONTH_DEC);
    // february 29 is let through here and settled once the leap test is known
    day_bad   = (cmd.load_day == 5'd0) || (cmd.load_day > month_len(cmd.load_month, 1'b1));

    push_data.op       = op_t'(cmd.opcode);
    push_data.amount   = AMOUNT_FIELD_W'(cmd.amount[AMT_W-1:0]);
    push_data.year     = cmd.load_year;
    push_data.month    = cmd.load_month;
    push_data.day      = cmd.load_day;
    push_data.load_bad = year_bad || month_bad || day_bad;
  end

endmodule

FILE: rtl/calendar_date_adder_core.sv
// top level of the calendar date adder: front end, command queue, back end
// depends on cda_pkg, cda_front, cda_fifo, cda_exec (and cda_cdiv below it)
//
// Keeps one Gregorian date (reset value 12 July 2012) and applies one command
// per transaction: add days, add months, add years, or load a date. Every
// command returns exactly one result carrying the date after the command and
// a status: ok, load rejected (date left unchanged), or year saturated (date
// pinned to 31 December of the largest year). Month and year adds clamp the
// day to the length of the new month. Commands enter a two-entry queue, so up
// to two may be taken while the back end is busy or its result is stalled.
// The back end works on one command at a time. A day add steps one month per
// cycle, and the largest day add crosses about 2150 months. Each command
// makes one pass of the reciprocal divider by 400 to keep the year modulo
// 400 for the leap test, so no wide remainder logic sits in the month walk;
// month adds and loads that pass the front-end checks make one more pass,
// by 12 or by 400. A stalled result holds the back end until it is taken.
module calendar_date_adder_core import cda_pkg::*; #(
  parameter int unsigned AMOUNT_WIDTH = 16,
  parameter int unsigned YEAR_WIDTH   = 16
) (
  input  logic         clk,
  input  logic         rst,
  // command channel
  input  logic         cmd_valid,
  output logic         cmd_stall,
  input  cmd_item_t    cmd,
  // result channel
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic    push;
  op_cmd_t push_data;
  logic    queue_full;
  logic    queue_ready;
  logic    queue_pop;
  op_cmd_t queue_head;

  // classify and pre-check commands on their way into the queue
  cda_front #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH),
    .YEAR_WIDTH   (YEAR_WIDTH)
  ) u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples acceptance from execution
  cda_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (queue_pop),
    .ready     (queue_ready),
    .pop_data  (queue_head)
  );

  // date state, month walk, divider and result register
  cda_exec #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH),
    .YEAR_WIDTH   (YEAR_WIDTH)
  ) u_exec (
    .clk          (clk),
    .rst          (rst),
    .cmd_ready    (queue_ready),
    .cmd          (queue_head),
    .cmd_pop      (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
